### design/tcw_pkg.sv
package tcw_pkg;

    // terminal bank geometry
    localparam int TERMINALS = 4;
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int MEM_DEPTH = TERMINALS * CELLS;

    // field and index widths
    localparam int TERM_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int POS_W  = 11;
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int IDX_W  = $clog2(MEM_DEPTH + 1);

    // stream and config port widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 3;
    localparam int CFG_IW   = 3;

    // config register indexes
    localparam logic [CFG_IW-1:0] CFG_ATTR_TERM0 = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ATTR_TERM1 = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ATTR_TERM2 = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ATTR_TERM3 = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SHOWN_TERM = 3'd4;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // tab stops every four columns
    localparam logic [COL_W:0] TAB_STEP = (COL_W + 1)'(4);
    localparam logic [COL_W:0] TAB_MASK = ~((COL_W + 1)'(3));

    // blank grey-on-black cell
    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'd7;

endpackage

### design/text_console_char_writer.sv
// Character writer for a bank of text-mode virtual terminals.
// Input stream: s_tdata carries one character byte, s_tuser the terminal index.
// Each transaction gives one result on the m_ stream: the cell written (if any),
// the new cursor position, a scroll flag and whether the terminal is on display.
// Configuration writes (cfg_we/cfg_index/cfg_data) set per-terminal color
// attributes and the shown terminal; they are taken on any cycle.
// Timing: an item is accepted in the idle state, passes through the MOVE and
// WRITE states, and its result is loaded into the output register at the end
// of WRITE; the next item is accepted back in idle once the output register is
// free or being drained. Both cursor positions go through one shared
// row*COLUMNS+column unit, used twice per item. A scroll walks the terminal's
// cell store through the single memory port pair, one cell copy per cycle,
// before the next item is taken; the result itself is already presented meanwhile.
// Reset: aresetn is synchronous active low; afterwards a clearing pass writes
// the blank cell to all TERMINALS*CELLS (8000) entries, one per cycle, and
// s_tready stays low until it is done.
// A stalled receiver holds the result in the output register; a new item is
// accepted only once that register is free or being drained.
module text_console_char_writer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcw_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] char_code
    input  logic [tcw_pkg::TERM_W-1:0]        s_tuser,   // [1:0] terminal
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]      m_tdata,   // [10:0] cell_address,
                                                         // [26:11] cell_value,
                                                         // [37:27] cursor_position,
                                                         // [39:38] zero
    output logic [tcw_pkg::M_USER_W-1:0]      m_tuser,   // [0] cell_written,
                                                         // [1] scrolled, [2] on_display
    // configuration
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IW-1:0]        cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MOVE   = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;

    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int POS_W  = tcw_pkg::POS_W;
    localparam int MEM_AW = tcw_pkg::MEM_AW;
    localparam int IDX_W  = tcw_pkg::IDX_W;

    localparam logic [COL_W:0]   COLS_LIM   = (COL_W + 1)'(tcw_pkg::COLUMNS);
    localparam logic [ROW_W:0]   ROWS_LIM   = (ROW_W + 1)'(tcw_pkg::ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [IDX_W-1:0] COPY_LEN   = IDX_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
    localparam logic [IDX_W-1:0] SCROLL_END = IDX_W'(tcw_pkg::CELLS);
    localparam logic [IDX_W-1:0] CLEAR_END  = IDX_W'(tcw_pkg::MEM_DEPTH - 1);

    // control state
    logic [2:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;

    // config registers
    logic [tcw_pkg::ATTR_W-1:0]    attr_reg [4];
    logic [tcw_pkg::TERM_W-1:0]    shown_reg;

    // per-terminal cursors
    logic [COL_W-1:0]              ccol_reg [tcw_pkg::TERMINALS];
    logic [ROW_W-1:0]              crow_reg [tcw_pkg::TERMINALS];

    // item being worked on
    logic [tcw_pkg::TERM_W-1:0]    term_reg;
    logic [tcw_pkg::CHAR_W-1:0]    char_reg;
    logic [tcw_pkg::ATTR_W-1:0]    iattr_reg;
    logic                          disp_reg;
    logic [COL_W-1:0]              ocol_reg, ncol_reg;
    logic [ROW_W-1:0]              orow_reg, nrow_reg;
    logic                          wr_reg, scroll_reg;
    logic [POS_W-1:0]              off_reg;
    logic [MEM_AW-1:0]             base_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [tcw_pkg::M_DATA_W-1:0]  m_tdata_reg;
    logic [tcw_pkg::M_USER_W-1:0]  m_tuser_reg;

    // cell store
    logic [tcw_pkg::CELL_W-1:0]    cell_mem [tcw_pkg::MEM_DEPTH];
    logic [tcw_pkg::CELL_W-1:0]    rd_data_reg;
    logic [MEM_AW-1:0]             mem_raddr, mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]    mem_wdata;
    logic                          mem_we;

    // shared position unit
    logic [ROW_W-1:0]              mul_row;
    logic [COL_W-1:0]              mul_col;
    logic [POS_W-1:0]              lin_pos;

    // cursor move logic
    logic [COL_W:0]                mv_col;
    logic [ROW_W:0]                mv_row;
    logic                          mv_wr, mv_scroll;
    logic [COL_W-1:0]              mv_col_fin;
    logic [ROW_W-1:0]              mv_row_fin;

    logic                          s_acc, term_ok;
    logic [tcw_pkg::CELL_W-1:0]    cell_val, blank_val;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign term_ok  = ({1'b0, s_tuser} < (tcw_pkg::TERM_W + 1)'(tcw_pkg::TERMINALS));
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign cell_val  = {iattr_reg, char_reg};
    assign blank_val = {iattr_reg, tcw_pkg::CH_SPACE};

    // row*COLUMNS+column, old cursor in MOVE and new cursor in WRITE
    always_comb begin
        if (state_reg == ST_MOVE) begin
            mul_row = orow_reg;
            mul_col = ocol_reg;
        end else begin
            mul_row = nrow_reg;
            mul_col = ncol_reg;
        end
        lin_pos = POS_W'(POS_W'(mul_row) * POS_W'(tcw_pkg::COLUMNS)) + POS_W'(mul_col);
    end

    // cursor movement for the current character
    always_comb begin
        mv_col = {1'b0, ocol_reg};
        mv_row = {1'b0, orow_reg};
        mv_wr  = 1'b0;
        case (char_reg)
            tcw_pkg::CH_NEWLINE: begin
                mv_col = '0;
                mv_row = mv_row + 1'b1;
            end
            tcw_pkg::CH_RETURN: begin
                mv_col = '0;
            end
            tcw_pkg::CH_TAB: begin
                mv_col = (mv_col + tcw_pkg::TAB_STEP) & tcw_pkg::TAB_MASK;
            end
            tcw_pkg::CH_BACKSPACE: begin
                if (mv_col != '0) mv_col = mv_col - 1'b1;
            end
            default: begin
                mv_wr  = 1'b1;
                mv_col = mv_col + 1'b1;
            end
        endcase
        // column overflow wraps to the next row
        if (mv_col >= COLS_LIM) begin
            mv_col = '0;
            mv_row = mv_row + 1'b1;
        end
        // row overflow scrolls and pins to the last row
        mv_scroll = (mv_row >= ROWS_LIM);
        mv_col_fin = mv_col[COL_W-1:0];
        mv_row_fin = mv_scroll ? LAST_ROW : mv_row[ROW_W-1:0];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CLEAR_END) begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            ST_IDLE: begin
                if (s_acc && term_ok) state_next = ST_MOVE;
            end
            ST_MOVE: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                idx_next   = '0;
                state_next = scroll_reg ? ST_SCROLL : ST_IDLE;
            end
            ST_SCROLL: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SCROLL_END) begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb begin
        mem_raddr = base_reg + MEM_AW'(idx_reg) + MEM_AW'(tcw_pkg::COLUMNS);
        mem_waddr = base_reg + MEM_AW'(off_reg);
        mem_wdata = cell_val;
        mem_we    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_waddr = MEM_AW'(idx_reg);
                mem_wdata = tcw_pkg::BLANK_RESET;
                mem_we    = 1'b1;
            end
            ST_WRITE: begin
                mem_we = wr_reg;
            end
            ST_SCROLL: begin
                // the write of each cell follows its read in the next cycle, using the registered read data
                mem_waddr = base_reg + MEM_AW'(idx_reg - 1'b1);
                mem_wdata = ((idx_reg - 1'b1) < COPY_LEN) ? rd_data_reg : blank_val;
                mem_we    = (idx_reg != '0);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // cell store ports
    always_ff @(posedge aclk) begin
        if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= cell_mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            shown_reg    <= '0;
            for (int i = 0; i < 4; i++) attr_reg[i] <= tcw_pkg::ATTR_RESET;
            for (int t = 0; t < tcw_pkg::TERMINALS; t++) begin
                ccol_reg[t] <= '0;
                crow_reg[t] <= '0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            // config writes
            if (cfg_we) begin
                case (cfg_index)
                    tcw_pkg::CFG_ATTR_TERM0: attr_reg[0] <= cfg_data;
                    tcw_pkg::CFG_ATTR_TERM1: attr_reg[1] <= cfg_data;
                    tcw_pkg::CFG_ATTR_TERM2: attr_reg[2] <= cfg_data;
                    tcw_pkg::CFG_ATTR_TERM3: attr_reg[3] <= cfg_data;
                    tcw_pkg::CFG_SHOWN_TERM: shown_reg <= cfg_data[tcw_pkg::TERM_W-1:0];
                    default: ;
                endcase
            end
            // cursor update
            if (state_reg == ST_MOVE) begin
                ccol_reg[term_reg] <= mv_col_fin;
                crow_reg[term_reg] <= mv_row_fin;
            end
            // output transaction handshake
            if (state_reg == ST_WRITE) m_tvalid_reg <= 1'b1;
            else if (m_tready)         m_tvalid_reg <= 1'b0;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            term_reg  <= s_tuser;
            char_reg  <= s_tdata;
            iattr_reg <= attr_reg[s_tuser];
            disp_reg  <= (s_tuser == shown_reg);
            ocol_reg  <= ccol_reg[s_tuser];
            orow_reg  <= crow_reg[s_tuser];
        end
        if (state_reg == ST_MOVE) begin
            ncol_reg   <= mv_col_fin;
            nrow_reg   <= mv_row_fin;
            wr_reg     <= mv_wr;
            scroll_reg <= mv_scroll;
            off_reg    <= lin_pos;
            base_reg   <= MEM_AW'(MEM_AW'(term_reg) * MEM_AW'(tcw_pkg::CELLS));
        end
        if (state_reg == ST_WRITE) begin
            m_tdata_reg <= {2'b00, lin_pos,
                            wr_reg ? cell_val : '0,
                            wr_reg ? off_reg : '0};
            m_tuser_reg <= {disp_reg, scroll_reg, wr_reg};
        end
    end

    // no intake during the clearing pass
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

    // the output register is always free when a result is loaded
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> !m_tvalid_reg)
        else $error("result overwrites a pending transaction");

    // a scroll always leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && scroll_reg) |-> (nrow_reg == LAST_ROW))
        else $error("scroll without cursor on last row");

    // the stored cursor column stays inside the row
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> ({1'b0, ncol_reg} < COLS_LIM))
        else $error("cursor column out of range");

    // the scroll walk's writes stay within one terminal store
    a_scroll_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL) |-> (idx_reg <= SCROLL_END))
        else $error("scroll walk overran the store");

endmodule
